[src/dlks_pkg.sv]
`default_nettype none
package dlks_pkg;

   // Request limits
   localparam int MAX_WORDS = 64;
   localparam int CNT_W     = $clog2(MAX_WORDS + 1);

   // Generator geometry and taps
   localparam int GEN_W     = 40;
   localparam int LO_W      = 32;
   localparam int TAP_X     = 17;
   localparam int TAP_Y     = 23;
   localparam int TAP_A     = 5;
   localparam int TAP_B     = 18;
   localparam int BYTES_PER_WORD = 4;

   // Seed constants
   localparam logic [7:0]  X_SEED_MARK      = 8'h60;
   localparam logic [38:0] SECOND_SEED_INIT = 39'h5C879B9B05;

   // Register map (8-byte stride)
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam logic [1:0] REG_CARD_SEED   = 2'd0;
   localparam logic [1:0] REG_KEY_BYTE    = 2'd1;
   localparam logic [1:0] REG_SECOND_SEED = 2'd2;

   // Command queue
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef struct packed {
      logic [23:0] card_seed;
      logic [7:0]  key_byte;
      logic [38:0] second_seed;
   } cfg_type;

   typedef struct packed {
      logic             is_load;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic [GEN_W-1:0] x;
      logic [GEN_W-1:0] y;
   } gen_pair_type;

   typedef struct packed {
      gen_pair_type g;
      logic [31:0]  word;
   } word_step_type;

   typedef struct packed {
      logic [GEN_W-1:0] g;
      logic [7:0]       nb;
   } byte_step_type;

   function automatic logic [31:0] bit_rev32(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[i] = v[31 - i];
      end
      return r;
   endfunction

   // Reverse both halves, then realign into the 40-bit register
   function automatic logic [GEN_W-1:0] seed_gen(input logic [31:0] a,
                                                 input logic [31:0] b);
      logic [31:0] ra;
      logic [31:0] rb;
      ra = bit_rev32(a);
      rb = bit_rev32(b);
      return {ra[31:24], ra[24:0], rb[31:25]};
   endfunction

   // One byte step of a generator with the given tap
   function automatic byte_step_type byte_step(input logic [GEN_W-1:0] g,
                                               input int tap);
      logic [LO_W-1:0] lo;
      logic [LO_W-1:0] mix;
      byte_step_type   r;
      lo   = g[LO_W-1:0];
      mix  = (lo >> TAP_A) ^ (lo >> tap) ^ (lo >> TAP_B);
      r.nb = mix[7:0] ^ g[GEN_W-1:LO_W];
      r.g  = {lo[30:23], lo[23:0], r.nb};
      return r;
   endfunction

   // Four byte steps of both generators, first byte lowest
   function automatic word_step_type word_step(input gen_pair_type g);
      word_step_type r;
      byte_step_type bx;
      byte_step_type by;
      r.g    = g;
      r.word = '0;
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         bx = byte_step(r.g.x, TAP_X);
         by = byte_step(r.g.y, TAP_Y);
         r.g.x = bx.g;
         r.g.y = by.g;
         r.word[8*b +: 8] = bx.nb ^ by.nb;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/dlks_if.sv]
`default_nettype none
interface dlks_req_if;
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [dlks_pkg::CNT_W-1:0] word_count;

   modport source (output valid, output action, output word_count, input ready);
   modport sink   (input valid, input action, input word_count, output ready);
endinterface

interface dlks_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] key_word;
   logic        last_word;

   modport source (output valid, output key_word, output last_word, input ready);
   modport sink   (input valid, input key_word, input last_word, output ready);
endinterface
`default_nettype wire

[src/dlks_csr.sv]
`default_nettype none
module dlks_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [dlks_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dlks_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [dlks_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output dlks_pkg::cfg_type                    cfg
);

   dlks_pkg::cfg_type cfg_ff;
   dlks_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:3];
   assign cfg        = cfg_ff;

   // Decode a write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            dlks_pkg::REG_CARD_SEED:   cfg_in.card_seed   = csr_pwdata[23:0];
            dlks_pkg::REG_KEY_BYTE:    cfg_in.key_byte    = csr_pwdata[7:0];
            dlks_pkg::REG_SECOND_SEED: cfg_in.second_seed = csr_pwdata[38:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         dlks_pkg::REG_CARD_SEED:   csr_prdata = {40'd0, cfg_ff.card_seed};
         dlks_pkg::REG_KEY_BYTE:    csr_prdata = {56'd0, cfg_ff.key_byte};
         dlks_pkg::REG_SECOND_SEED: csr_prdata = {25'd0, cfg_ff.second_seed};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.card_seed   <= '0;
         cfg_ff.key_byte    <= '0;
         cfg_ff.second_seed <= dlks_pkg::SECOND_SEED_INIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[src/dlks_front.sv]
`default_nettype none
module dlks_front (
   dlks_req_if.sink          req,
   input  wire logic         q_full,
   output logic              q_push,
   output dlks_pkg::cmd_type q_cmd
);

   logic xfer;

   assign req.ready = !q_full;
   assign xfer      = req.valid && !q_full;

   // Classify: saturate the count, drop empty generate requests
   always_comb begin
      q_cmd.is_load = !req.action;
      if (req.word_count > dlks_pkg::CNT_W'(dlks_pkg::MAX_WORDS)) begin
         q_cmd.count = dlks_pkg::CNT_W'(dlks_pkg::MAX_WORDS);
      end else begin
         q_cmd.count = req.word_count;
      end
      q_push = xfer && (!req.action || (req.word_count != '0));
   end

endmodule
`default_nettype wire

[src/dlks_cmd_fifo.sv]
`default_nettype none
module dlks_cmd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dlks_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output dlks_pkg::cmd_type      head_cmd
);

   dlks_pkg::cmd_type                slot_ff [dlks_pkg::CMD_DEPTH];
   logic [dlks_pkg::CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [dlks_pkg::CMD_PTR_W-1:0]   wr_ptr_in;
   logic [dlks_pkg::CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [dlks_pkg::CMD_PTR_W-1:0]   rd_ptr_in;
   logic [dlks_pkg::CMD_CNT_W-1:0]   count_ff;
   logic [dlks_pkg::CMD_CNT_W-1:0]   count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full     = (count_ff == dlks_pkg::CMD_CNT_W'(dlks_pkg::CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[src/dlks_back.sv]
`default_nettype none
module dlks_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dlks_pkg::cfg_type cfg,
   input  wire logic              q_empty,
   input  wire dlks_pkg::cmd_type q_cmd,
   output logic                   q_pop,
   dlks_rsp_if.source             rsp
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                    state_ff;
   state_type                    state_in;
   dlks_pkg::gen_pair_type       gen_ff;
   dlks_pkg::gen_pair_type       gen_in;
   logic [dlks_pkg::CNT_W-1:0]   words_left_ff;
   logic [dlks_pkg::CNT_W-1:0]   words_left_in;
   logic                         valid_ff;
   logic                         valid_in;
   logic [31:0]                  key_word_ff;
   logic [31:0]                  key_word_in;
   logic                         last_word_ff;
   logic                         last_word_in;
   logic                         fire;
   logic [31:0]                  x_seed_a;
   logic [31:0]                  x_seed_b;
   dlks_pkg::word_step_type      ws;

   assign rsp.valid     = valid_ff;
   assign rsp.key_word  = key_word_ff;
   assign rsp.last_word = last_word_ff;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;
   assign fire  = (state_ff == ST_RUN) && (!valid_ff || rsp.ready);

   // Seed words of generator X: card seed from bit 15 up, overlapping the mark byte
   assign x_seed_a = {cfg.card_seed[16:0], 15'd0} |
                     {16'd0, dlks_pkg::X_SEED_MARK, cfg.key_byte};
   assign x_seed_b = {25'd0, cfg.card_seed[23:17]};

   assign ws = dlks_pkg::word_step(gen_ff);

   // Take a command, or produce one word per free output slot
   always_comb begin
      state_in      = state_ff;
      gen_in        = gen_ff;
      words_left_in = words_left_ff;
      valid_in      = valid_ff;
      key_word_in   = key_word_ff;
      last_word_in  = last_word_ff;

      if (rsp.ready) begin
         valid_in = 1'b0;
      end

      if (q_pop) begin
         if (q_cmd.is_load) begin
            gen_in.x = dlks_pkg::seed_gen(x_seed_a, x_seed_b);
            gen_in.y = dlks_pkg::seed_gen(cfg.second_seed[31:0],
                                          {25'd0, cfg.second_seed[38:32]});
         end else begin
            words_left_in = q_cmd.count;
            state_in      = ST_RUN;
         end
      end

      if (fire) begin
         gen_in        = ws.g;
         valid_in      = 1'b1;
         key_word_in   = ws.word;
         last_word_in  = (words_left_ff == dlks_pkg::CNT_W'(1));
         words_left_in = words_left_ff - 1'b1;
         if (words_left_ff == dlks_pkg::CNT_W'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gen_ff        <= '0;
         words_left_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gen_ff        <= gen_in;
         words_left_ff <= words_left_in;
         valid_ff      <= valid_in;
      end
      key_word_ff  <= key_word_in;
      last_word_ff <= last_word_in;
   end

   // A running request always has words to go
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (words_left_ff != '0))
      else $error("running with no words left");

   // The final word returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && (words_left_ff == dlks_pkg::CNT_W'(1))) |=>
         ((state_ff == ST_IDLE) && valid_ff && last_word_ff))
      else $error("final word did not end the request");

   // Remaining count never exceeds the request limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      words_left_ff <= dlks_pkg::CNT_W'(dlks_pkg::MAX_WORDS))
      else $error("word count above limit");

   // No new command is taken while a request runs
   a_no_pop_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !q_pop)
      else $error("command taken during a request");

endmodule
`default_nettype wire

[src/dual_lfsr_keystream_generator_core.sv]
`default_nettype none
// Dual shift-register keystream generator. A request with action 0 reseeds
// generators X and Y from the card_seed, key_byte and second_seed registers
// and returns nothing; a request with action 1 returns word_count keystream
// words (saturated at 64, none for a count of zero), one word per transfer,
// first byte in bits 7:0, last_word set on the final one. Requests pass
// through a two-entry command queue, so up to two may be taken while the
// generators are busy. Once a generate request reaches the word engine it
// produces one word per cycle while the output is not stalled (four byte
// steps of both generators per word, done combinationally). The engine
// takes a command only while idle: a load reseeds as it is taken, and a
// generate request then runs until its last word. A request enters the
// queue at its transfer. Write the registers only while the block is idle.
module dual_lfsr_keystream_generator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [dlks_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dlks_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [dlks_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   dlks_req_if.sink                             req_if,
   dlks_rsp_if.source                           rsp_if
);

   dlks_pkg::cfg_type cfg;
   dlks_pkg::cmd_type push_cmd;
   dlks_pkg::cmd_type head_cmd;
   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_empty;

   dlks_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dlks_front u_front (
      .req    (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   dlks_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   dlks_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_cmd   (head_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp_if)
   );

endmodule
`default_nettype wire

[dv/dual_lfsr_keystream_generator_core_tb.sv]
`timescale 1ns / 1ps
module dual_lfsr_keystream_generator_core_tb;

   localparam logic       ACT_LOAD     = 1'b0;
   localparam logic       ACT_GENERATE = 1'b1;
   localparam logic [1:0] REG_UNUSED   = 2'd3;
   localparam int         QUIET_CYCLES = 20;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         PHASE_ITEMS  = 100;

   typedef struct packed {
      logic [31:0] key_word;
      logic        last_word;
   } key_word_type;

   // Keystream predictor and store of words still owed by the block
   class keystream_board;
      logic [23:0]  card_seed;
      logic [7:0]   key_byte;
      logic [38:0]  second_seed;
      logic [39:0]  gen_x;
      logic [39:0]  gen_y;
      key_word_type pending_words[$];
      int           errors;

      function new();
         card_seed   = '0;
         key_byte    = '0;
         second_seed = dlks_pkg::SECOND_SEED_INIT;
         gen_x       = '0;
         gen_y       = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] value);
         case (idx)
            dlks_pkg::REG_CARD_SEED:   card_seed   = value[23:0];
            dlks_pkg::REG_KEY_BYTE:    key_byte    = value[7:0];
            dlks_pkg::REG_SECOND_SEED: second_seed = value[38:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] mirror32(logic [31:0] v);
         logic [31:0] r;
         for (int i = 0; i < 32; i++) begin
            r[31 - i] = v[i];
         end
         return r;
      endfunction

      // Reverse both halves, then realign into the high byte and low word
      function logic [39:0] seeded(logic [31:0] a, logic [31:0] b);
         logic [31:0] ra;
         logic [31:0] rb;
         logic [31:0] lo;
         ra = mirror32(a);
         rb = mirror32(b);
         lo = (rb >> 25) | (ra << 7);
         return {ra[31:24], lo};
      endfunction

      function logic [7:0] new_byte(logic [39:0] g, int tap);
         logic [31:0] lo;
         logic [31:0] mix;
         lo  = g[31:0];
         mix = (lo >> dlks_pkg::TAP_A) ^ (lo >> tap) ^ (lo >> dlks_pkg::TAP_B);
         return mix[7:0] ^ g[39:32];
      endfunction

      // Reseed on a load, else queue the words a generate owes
      function void note_request(logic action, logic [dlks_pkg::CNT_W-1:0] count);
         logic [31:0]  xa;
         logic [31:0]  xb;
         logic [31:0]  word;
         logic [7:0]   bx;
         logic [7:0]   by;
         int           n;
         key_word_type e;
         if (action == ACT_LOAD) begin
            xa    = (32'(card_seed) << 15) | {16'd0, dlks_pkg::X_SEED_MARK, 8'd0}
                    | 32'(key_byte);
            xb    = 32'(card_seed) >> 17;
            gen_x = seeded(xa, xb);
            gen_y = seeded(second_seed[31:0], 32'(second_seed[38:32]));
         end else begin
            n = (count > dlks_pkg::MAX_WORDS) ? dlks_pkg::MAX_WORDS : int'(count);
            for (int w = 0; w < n; w++) begin
               for (int b = 0; b < 4; b++) begin
                  bx    = new_byte(gen_x, dlks_pkg::TAP_X);
                  by    = new_byte(gen_y, dlks_pkg::TAP_Y);
                  gen_x = {gen_x[30:23], gen_x[23:0], bx};
                  gen_y = {gen_y[30:23], gen_y[23:0], by};
                  word[8*b +: 8] = bx ^ by;
               end
               e.key_word  = word;
               e.last_word = (w == n - 1);
               pending_words.push_back(e);
            end
         end
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_word(logic [31:0] word, logic last);
         key_word_type e;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected word %h last %b", word, last));
         end else begin
            e = pending_words.pop_front();
            if (word !== e.key_word)
               report($sformatf("key_word %h, want %h", word, e.key_word));
            if (last !== e.last_word)
               report($sformatf("last_word %b, want %b", last, e.last_word));
         end
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [dlks_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [dlks_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [dlks_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;
   int                              send_idle_pct;
   int                              rsp_stall_pct;
   int                              cycles;
   int                              idle_table[4]  = '{0, 61, 0, 24};
   int                              stall_table[4] = '{0, 0, 61, 24};
   keystream_board                  board;

   dlks_req_if req_if();
   dlks_rsp_if rsp_if();

   dual_lfsr_keystream_generator_core DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   always #5 clock = ~clock;

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check every word transfer
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_word(rsp_if.key_word, rsp_if.last_word);
   end

   // Hold the request until its transfer, after an optional random gap
   task automatic send_request(logic action, logic [dlks_pkg::CNT_W-1:0] count);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= action;
      req_if.word_count <= count;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_request(action, count);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drop valid, wait for every owed word, then let queued loads finish
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_value(int width);
      logic [63:0] mask;
      mask = (64'd1 << width) - 64'd1;
      case ($urandom_range(3))
         0:       return '0;
         1:       return mask;
         default: return {$urandom, $urandom} & mask;
      endcase
   endfunction

   function automatic logic [dlks_pkg::CNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 5)       return '0;
      else if (r < 80) return dlks_pkg::CNT_W'($urandom_range(12, 1));
      else if (r < 95) return dlks_pkg::CNT_W'($urandom_range(dlks_pkg::MAX_WORDS, 13));
      else             return dlks_pkg::CNT_W'($urandom_range(127, dlks_pkg::MAX_WORDS + 1));
   endfunction

   task automatic new_settings();
      settle();
      csr_write(dlks_pkg::REG_CARD_SEED, pick_value(24));
      csr_write(dlks_pkg::REG_KEY_BYTE, pick_value(8));
      csr_write(dlks_pkg::REG_SECOND_SEED, pick_value(39));
   endtask

   // Timeout
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic action;
      board             = new();
      req_if.valid      = 1'b0;
      req_if.action     = ACT_LOAD;
      req_if.word_count = '0;
      rsp_if.ready      = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      send_idle_pct     = 0;
      rsp_stall_pct     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Generate before any load, then the count corners on the reset seeds
      send_request(ACT_GENERATE, 7'd3);
      send_request(ACT_LOAD, 7'd0);
      send_request(ACT_GENERATE, 7'd1);
      send_request(ACT_GENERATE, 7'd0);
      send_request(ACT_GENERATE, 7'd64);
      send_request(ACT_GENERATE, 7'd65);
      send_request(ACT_GENERATE, 7'd127);
      send_request(ACT_LOAD, 7'd127);
      send_request(ACT_GENERATE, 7'd2);

      // All-ones seeds; a write to an unmapped register is dropped
      settle();
      csr_write(dlks_pkg::REG_CARD_SEED, 64'hFF_FFFF);
      csr_write(dlks_pkg::REG_KEY_BYTE, 64'hFF);
      csr_write(dlks_pkg::REG_SECOND_SEED, 64'h7F_FFFF_FFFF);
      csr_write(REG_UNUSED, '1);
      send_request(ACT_LOAD, 7'd5);
      send_request(ACT_GENERATE, 7'd4);

      // All-zero seeds
      settle();
      csr_write(dlks_pkg::REG_CARD_SEED, '0);
      csr_write(dlks_pkg::REG_KEY_BYTE, '0);
      csr_write(dlks_pkg::REG_SECOND_SEED, '0);
      send_request(ACT_LOAD, 7'd0);
      send_request(ACT_GENERATE, 7'd2);

      // Random requests under each idling mix, reseeding now and then
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_table[p];
         rsp_stall_pct = stall_table[p];
         new_settings();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == 35 || i == 70)
               new_settings();
            action = ($urandom_range(99) < 20) ? ACT_LOAD : ACT_GENERATE;
            send_request(action, (action == ACT_LOAD) ? dlks_pkg::CNT_W'($urandom)
                                                      : pick_count());
         end
      end

      settle();
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
src/dlks_pkg.sv
src/dlks_if.sv
src/dlks_csr.sv
src/dlks_front.sv
src/dlks_cmd_fifo.sv
src/dlks_back.sv
src/dual_lfsr_keystream_generator_core.sv
dv/dual_lfsr_keystream_generator_core_tb.sv
